FILE: sv/sfc_pkg.sv
package sfc_pkg;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_CMD     = 4'd1,
        PH_NETH    = 4'd2,
        PH_NETL    = 4'd3,
        PH_ADDR    = 4'd4,
        PH_ACK     = 4'd5,
        PH_LEN     = 4'd6,
        PH_PAYLOAD = 4'd7,
        PH_CHECK   = 4'd8,
        PH_DRAIN   = 4'd9
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_HEADER = 3'd1,
        ST_TRUNCATED = 3'd2,
        ST_BAD_CMD   = 3'd3,
        ST_BAD_SUM   = 3'd4,
        ST_WRONG_NET = 3'd5,
        ST_BAD_LEN   = 3'd6
    } t_status;

    localparam logic       KIND_PAYLOAD = 1'b0;
    localparam logic       KIND_STATUS  = 1'b1;

    localparam int         CFG_IDX_W  = 2;
    localparam int         CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NET_ID  = 2'd2;

    localparam logic [7:0]  HEADER_RST  = 8'h55;
    localparam logic [7:0]  COMMAND_RST = 8'h01;
    localparam logic [15:0] NET_ID_RST  = 16'hD0C2;

    typedef struct packed {
        logic [7:0]  header_byte;
        logic [7:0]  expected_command;
        logic [15:0] own_network_id;
    } t_cfg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_packet;
    } t_rx_item;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] payload_byte;
        t_status    frame_status;
        logic [7:0] source_address;
        logic [7:0] ack_code;
    } t_result;

endpackage

FILE: sv/sfc_in_stage.sv
module sfc_in_stage
    import sfc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_rx_item i_item,
    input  logic     i_advance,
    output logic     o_valid,
    output t_rx_item o_item
);

    logic     r_valid;
    logic     n_valid;
    t_rx_item r_item;

    // free when empty or when the held item moves on this cycle
    assign o_ready = !r_valid || i_advance;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: sv/sfc_parser.sv
module sfc_parser
    import sfc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_advance,
    input  t_rx_item i_item,
    output logic     o_emit,
    output t_result  o_result
);

    t_phase     r_phase,     n_phase;
    logic [7:0] r_sum,       n_sum;
    logic [7:0] r_left,      n_left;
    logic [7:0] r_net_hi,    n_net_hi;
    logic [7:0] r_addr,      n_addr;
    logic [7:0] r_ack,       n_ack;
    logic       r_cmd_bad,   n_cmd_bad;
    logic       r_net_bad,   n_net_bad;

    logic [7:0] b;
    logic       last;
    logic [7:0] left_dec;

    assign b        = i_item.rx_byte;
    assign last     = i_item.end_of_packet;
    assign left_dec = r_left - 8'd1;

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_sum     = r_sum;
        n_left    = r_left;
        n_net_hi  = r_net_hi;
        n_addr    = r_addr;
        n_ack     = r_ack;
        n_cmd_bad = r_cmd_bad;
        n_net_bad = r_net_bad;
        case (r_phase)
            PH_HUNT: begin
                if (b == i_cfg.header_byte) begin
                    n_sum     = b;
                    n_addr    = 8'd0;
                    n_ack     = 8'd0;
                    n_net_hi  = 8'd0;
                    n_left    = 8'd0;
                    n_cmd_bad = 1'b0;
                    n_net_bad = 1'b0;
                    n_phase   = last ? PH_HUNT : PH_CMD;
                end
            end
            PH_CHECK: begin
                n_phase = last ? PH_HUNT : PH_DRAIN;
            end
            PH_DRAIN: begin
                if (last) begin
                    n_phase = PH_HUNT;
                end
            end
            PH_CMD, PH_NETH, PH_NETL, PH_ADDR, PH_ACK, PH_LEN, PH_PAYLOAD: begin
                n_sum = r_sum + b;
                if (r_phase == PH_LEN && b == 8'd0) begin
                    n_phase = last ? PH_HUNT : PH_DRAIN;
                end else if (last) begin
                    n_phase = PH_HUNT;
                end else begin
                    case (r_phase)
                        PH_CMD: begin
                            n_cmd_bad = (b != i_cfg.expected_command);
                            n_phase   = PH_NETH;
                        end
                        PH_NETH: begin
                            n_net_hi = b;
                            n_phase  = PH_NETL;
                        end
                        PH_NETL: begin
                            n_net_bad = ({r_net_hi, b} != i_cfg.own_network_id);
                            n_phase   = PH_ADDR;
                        end
                        PH_ADDR: begin
                            n_addr  = b;
                            n_phase = PH_ACK;
                        end
                        PH_ACK: begin
                            n_ack   = b;
                            n_phase = PH_LEN;
                        end
                        PH_LEN: begin
                            n_left  = b - 8'd1;
                            n_phase = (b == 8'd1) ? PH_CHECK : PH_PAYLOAD;
                        end
                        PH_PAYLOAD: begin
                            n_left = left_dec;
                            if (left_dec == 8'd0) begin
                                n_phase = PH_CHECK;
                            end
                        end
                        default: begin
                            n_phase = PH_HUNT;
                        end
                    endcase
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    // result
    always_comb begin
        o_emit                  = 1'b0;
        o_result.item_kind      = KIND_STATUS;
        o_result.payload_byte   = 8'd0;
        o_result.frame_status   = ST_OK;
        o_result.source_address = n_addr;
        o_result.ack_code       = n_ack;
        case (r_phase)
            PH_HUNT: begin
                if (b == i_cfg.header_byte) begin
                    if (last) begin
                        o_emit                = 1'b1;
                        o_result.frame_status = ST_TRUNCATED;
                    end
                end else if (last) begin
                    o_emit                = 1'b1;
                    o_result.frame_status = ST_NO_HEADER;
                end
            end
            PH_CHECK: begin
                o_emit = 1'b1;
                if (r_cmd_bad) begin
                    o_result.frame_status = ST_BAD_CMD;
                end else if (b != r_sum) begin
                    o_result.frame_status = ST_BAD_SUM;
                end else if (r_net_bad) begin
                    o_result.frame_status = ST_WRONG_NET;
                end else begin
                    o_result.frame_status = ST_OK;
                end
            end
            PH_CMD, PH_NETH, PH_NETL, PH_ADDR, PH_ACK, PH_LEN, PH_PAYLOAD: begin
                if (r_phase == PH_LEN && b == 8'd0) begin
                    o_emit                = 1'b1;
                    o_result.frame_status = ST_BAD_LEN;
                end else if (last) begin
                    o_emit                = 1'b1;
                    o_result.frame_status = ST_TRUNCATED;
                end else if (r_phase == PH_PAYLOAD && !r_cmd_bad && !r_net_bad) begin
                    o_emit                = 1'b1;
                    o_result.item_kind    = KIND_PAYLOAD;
                    o_result.payload_byte = b;
                end
            end
            default: begin
                o_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_sum     <= 8'd0;
            r_left    <= 8'd0;
            r_net_hi  <= 8'd0;
            r_addr    <= 8'd0;
            r_ack     <= 8'd0;
            r_cmd_bad <= 1'b0;
            r_net_bad <= 1'b0;
        end else if (i_advance) begin
            r_phase   <= n_phase;
            r_sum     <= n_sum;
            r_left    <= n_left;
            r_net_hi  <= n_net_hi;
            r_addr    <= n_addr;
            r_ack     <= n_ack;
            r_cmd_bad <= n_cmd_bad;
            r_net_bad <= n_net_bad;
        end
    end

endmodule

FILE: sv/sfc_out_stage.sv
module sfc_out_stage
    import sfc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: sv/sensor_reply_frame_checker_top.sv
// Sensor reply frame checker.
// Input channel: one received byte per item (i_rx_byte, i_end_of_packet on the
// packet's last byte) under i_in_valid / o_in_ready. Output channel: one item
// per payload byte of a frame whose command and net id match, and one status
// item closing each frame or packet, under o_out_valid / i_out_ready.
// Configuration: write header byte, command and network id through
// i_cfg_we / i_cfg_index / i_cfg_data while no byte is in flight.
// Throughput: one byte per cycle, sustained while i_out_ready stays high. The parse step is a compare and
// an 8-bit add between the input register and the result register.
// Path: an accepted byte waits in the input register; when it moves on, its
// result is loaded into the result register, from where it can be taken
// (input register, then result register).
// Stall: while a result waits on i_out_ready the input register still takes
// one more byte; then o_in_ready drops until the result is taken, whether or
// not that byte makes a result.
// Reset (synchronous, active low): registers return to header 0x55,
// command 0x01, net id 0xD0C2, the parser hunts for a header, both channels
// empty. o_in_ready is high as soon as reset is released.
module sensor_reply_frame_checker_top
    import sfc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_end_of_packet,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_item_kind,
    output logic [7:0]            o_payload_byte,
    output logic [2:0]            o_frame_status,
    output logic [7:0]            o_source_address,
    output logic [7:0]            o_ack_code,
    output logic                  o_run_last,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg     r_cfg;
    t_rx_item in_item;
    t_rx_item held_item;
    logic     held_valid;
    logic     advance;
    logic     emit;
    t_result  step_result;
    t_result  out_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_byte      <= HEADER_RST;
            r_cfg.expected_command <= COMMAND_RST;
            r_cfg.own_network_id   <= NET_ID_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HEADER:  r_cfg.header_byte      <= i_cfg_data[7:0];
                CFG_COMMAND: r_cfg.expected_command <= i_cfg_data[7:0];
                CFG_NET_ID:  r_cfg.own_network_id   <= i_cfg_data;
                default:     r_cfg                  <= r_cfg;
            endcase
        end
    end

    assign in_item.rx_byte       = i_rx_byte;
    assign in_item.end_of_packet = i_end_of_packet;

    // move the held byte on whenever the result register can take its result
    assign advance = held_valid && (!o_out_valid || i_out_ready);

    sfc_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    sfc_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_advance (advance),
        .i_item    (held_item),
        .o_emit    (emit),
        .o_result  (step_result)
    );

    sfc_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && emit),
        .i_result (step_result),
        .i_ready  (i_out_ready),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_item_kind      = out_result.item_kind;
    assign o_payload_byte   = out_result.payload_byte;
    assign o_frame_status   = out_result.frame_status;
    assign o_source_address = out_result.source_address;
    assign o_ack_code       = out_result.ack_code;
    assign o_run_last       = out_result.item_kind;

endmodule

FILE: tb/sensor_reply_frame_checker_top_tb.sv
`timescale 1ns / 100ps

module sensor_reply_frame_checker_top_tb;
    import sfc_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_BYTES = 1450;
    localparam int DRAIN_CYCLES = 4;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [7:0]            i_rx_byte = 8'h00;
    logic                  i_end_of_packet = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_item_kind;
    logic [7:0]            o_payload_byte;
    logic [2:0]            o_frame_status;
    logic [7:0]            o_source_address;
    logic [7:0]            o_ack_code;
    logic                  o_run_last;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_HEADER;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    sensor_reply_frame_checker_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_rx_byte        (i_rx_byte),
        .i_end_of_packet  (i_end_of_packet),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_item_kind      (o_item_kind),
        .o_payload_byte   (o_payload_byte),
        .o_frame_status   (o_frame_status),
        .o_source_address (o_source_address),
        .o_ack_code       (o_ack_code),
        .o_run_last       (o_run_last),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // Parser model state and its copy of the registers
    logic [7:0]  cfg_header;
    logic [7:0]  cfg_command;
    logic [15:0] cfg_net_id;
    t_phase      ph;
    logic [7:0]  sum_acc;
    logic [7:0]  bytes_left;
    logic [7:0]  net_hi;
    logic [7:0]  held_addr;
    logic [7:0]  held_ack;
    logic        cmd_bad;
    logic        net_bad;

    t_result     expected_replies[$];
    logic [7:0]  pkt_bytes[$];
    int          mismatch_count = 0;
    int          bytes_sent = 0;
    int          quiet_cycles = 0;
    bit          idling_on = 1'b1;

    initial forever #1 i_clk = ~i_clk;

    function automatic logic [7:0] rand8();
        return 8'($urandom);
    endfunction

    function automatic void predict_frame_byte(input logic [7:0] b, input logic eop);
        t_result r;
        logic    emit;
        emit           = 1'b0;
        r              = '0;
        r.frame_status = ST_OK;
        case (ph)
            PH_HUNT: begin
                if (b == cfg_header) begin
                    sum_acc    = b;
                    held_addr  = '0;
                    held_ack   = '0;
                    net_hi     = '0;
                    bytes_left = '0;
                    cmd_bad    = 1'b0;
                    net_bad    = 1'b0;
                    ph         = eop ? PH_HUNT : PH_CMD;
                    if (eop) begin
                        emit           = 1'b1;
                        r.item_kind    = KIND_STATUS;
                        r.frame_status = ST_TRUNCATED;
                    end
                end else if (eop) begin
                    emit           = 1'b1;
                    r.item_kind    = KIND_STATUS;
                    r.frame_status = ST_NO_HEADER;
                end
            end
            PH_CHECK: begin
                emit        = 1'b1;
                r.item_kind = KIND_STATUS;
                if (cmd_bad)
                    r.frame_status = ST_BAD_CMD;
                else if (b != sum_acc)
                    r.frame_status = ST_BAD_SUM;
                else if (net_bad)
                    r.frame_status = ST_WRONG_NET;
                else
                    r.frame_status = ST_OK;
                ph = eop ? PH_HUNT : PH_DRAIN;
            end
            PH_DRAIN: begin
                if (eop)
                    ph = PH_HUNT;
            end
            default: begin
                sum_acc = sum_acc + b;
                if (ph == PH_LEN && b == 8'd0) begin
                    emit           = 1'b1;
                    r.item_kind    = KIND_STATUS;
                    r.frame_status = ST_BAD_LEN;
                    ph             = eop ? PH_HUNT : PH_DRAIN;
                end else if (eop) begin
                    emit           = 1'b1;
                    r.item_kind    = KIND_STATUS;
                    r.frame_status = ST_TRUNCATED;
                    ph             = PH_HUNT;
                end else begin
                    case (ph)
                        PH_CMD: begin
                            cmd_bad = (b != cfg_command);
                            ph      = PH_NETH;
                        end
                        PH_NETH: begin
                            net_hi = b;
                            ph     = PH_NETL;
                        end
                        PH_NETL: begin
                            net_bad = ({net_hi, b} != cfg_net_id);
                            ph      = PH_ADDR;
                        end
                        PH_ADDR: begin
                            held_addr = b;
                            ph        = PH_ACK;
                        end
                        PH_ACK: begin
                            held_ack = b;
                            ph       = PH_LEN;
                        end
                        PH_LEN: begin
                            bytes_left = b - 8'd1;
                            ph         = (bytes_left == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                        end
                        PH_PAYLOAD: begin
                            bytes_left = bytes_left - 8'd1;
                            if (bytes_left == 8'd0)
                                ph = PH_CHECK;
                            if (!cmd_bad && !net_bad) begin
                                emit           = 1'b1;
                                r.item_kind    = KIND_PAYLOAD;
                                r.payload_byte = b;
                            end
                        end
                        default: ph = PH_HUNT;
                    endcase
                end
            end
        endcase
        if (emit) begin
            r.source_address = held_addr;
            r.ack_code       = held_ack;
            expected_replies.push_back(r);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t: %s got %0h expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : check_reply
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_replies.size() == 0) begin
                report_mismatch("result with none pending", 16'(o_frame_status), 16'h0);
            end else begin
                want = expected_replies.pop_front();
                if (o_item_kind !== want.item_kind)
                    report_mismatch("item_kind", 16'(o_item_kind), 16'(want.item_kind));
                if (o_payload_byte !== want.payload_byte)
                    report_mismatch("payload_byte", 16'(o_payload_byte),
                                    16'(want.payload_byte));
                if (o_frame_status !== want.frame_status)
                    report_mismatch("frame_status", 16'(o_frame_status),
                                    16'(want.frame_status));
                if (o_source_address !== want.source_address)
                    report_mismatch("source_address", 16'(o_source_address),
                                    16'(want.source_address));
                if (o_ack_code !== want.ack_code)
                    report_mismatch("ack_code", 16'(o_ack_code), 16'(want.ack_code));
                if (o_run_last !== want.item_kind)
                    report_mismatch("run_last", 16'(o_run_last), 16'(want.item_kind));
            end
        end
    end

    always @(posedge i_clk)
        i_out_ready <= !(idling_on && $urandom_range(0, 99) < 11);

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("sensor_reply_frame_checker_top_tb: FAIL");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eop);
        if (idling_on && $urandom_range(0, 99) < 11) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_rx_byte       <= b;
        i_end_of_packet <= eop;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        predict_frame_byte(b, eop);
        bytes_sent++;
    endtask

    task automatic send_packet();
        int n;
        n = pkt_bytes.size();
        for (int k = 0; k < n; k++)
            send_byte(pkt_bytes[k], k == n - 1);
        pkt_bytes.delete();
    endtask

    // Hold the sender until every pending result is back, then let the pipe empty
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_HEADER:  cfg_header  = value[7:0];
            CFG_COMMAND: cfg_command = value[7:0];
            CFG_NET_ID:  cfg_net_id  = value;
            default: ;
        endcase
    endtask

    function automatic void add_noise(input int n, input logic skip_header);
        logic [7:0] v;
        repeat (n) begin
            v = rand8();
            if (skip_header && v == cfg_header)
                v = v ^ 8'h01;
            pkt_bytes.push_back(v);
        end
    endfunction

    function automatic void build_frame(input logic [7:0] cmd, input logic [15:0] net,
                                        input logic [7:0] addr, input logic [7:0] ack,
                                        input logic [7:0] len, input logic [7:0] sum_flip);
        logic [7:0] sum;
        logic [7:0] v;
        sum = cfg_header + cmd + net[15:8] + net[7:0] + addr + ack + len;
        pkt_bytes.push_back(cfg_header);
        pkt_bytes.push_back(cmd);
        pkt_bytes.push_back(net[15:8]);
        pkt_bytes.push_back(net[7:0]);
        pkt_bytes.push_back(addr);
        pkt_bytes.push_back(ack);
        pkt_bytes.push_back(len);
        for (int k = 1; k < int'(len); k++) begin
            v   = rand8();
            sum = sum + v;
            pkt_bytes.push_back(v);
        end
        pkt_bytes.push_back(sum ^ sum_flip);
    endfunction

    function automatic void cut_packet(input int keep);
        while (pkt_bytes.size() > keep)
            void'(pkt_bytes.pop_back());
    endfunction

    task automatic test_good_frames();
        build_frame(cfg_command, cfg_net_id, 8'h00, 8'hFF, 8'd1, 8'h00);
        send_packet();
        build_frame(cfg_command, cfg_net_id, 8'hFF, 8'h00, 8'd4, 8'h00);
        send_packet();
        build_frame(cfg_command, cfg_net_id, rand8(), rand8(), 8'd255, 8'h00);
        send_packet();
        settle();
    endtask

    task automatic test_status_codes();
        // command and net both wrong: command wins, no payload goes out
        build_frame(~cfg_command, ~cfg_net_id, rand8(), rand8(), 8'd3, 8'h00);
        send_packet();
        build_frame(cfg_command, cfg_net_id, rand8(), rand8(), 8'd3, 8'h80);
        send_packet();
        build_frame(cfg_command, cfg_net_id ^ 16'h0001, rand8(), rand8(), 8'd2, 8'h00);
        send_packet();
        // bad sum outranks wrong net
        build_frame(cfg_command, cfg_net_id ^ 16'h8000, rand8(), rand8(), 8'd2, 8'h01);
        send_packet();
        // zero length with a bad command, the tail gets dropped
        build_frame(~cfg_command, cfg_net_id, rand8(), rand8(), 8'd0, 8'h00);
        add_noise(3, 1'b0);
        send_packet();
        // zero length on the packet's last byte
        build_frame(cfg_command, cfg_net_id, rand8(), rand8(), 8'd0, 8'h00);
        cut_packet(7);
        send_packet();
        add_noise(5, 1'b1);
        send_packet();
        add_noise(1, 1'b1);
        send_packet();
        pkt_bytes.push_back(cfg_header);
        send_packet();
        // end early: in the header body, on the length, before the checksum
        build_frame(cfg_command, cfg_net_id, rand8(), rand8(), 8'd5, 8'h00);
        cut_packet(2);
        send_packet();
        build_frame(cfg_command, cfg_net_id, rand8(), rand8(), 8'd5, 8'h00);
        cut_packet(7);
        send_packet();
        build_frame(cfg_command, cfg_net_id, rand8(), rand8(), 8'd6, 8'h00);
        cut_packet(pkt_bytes.size() - 1);
        send_packet();
        // noise ahead of the header; a header value inside the tail is ignored
        add_noise(3, 1'b1);
        build_frame(cfg_command, cfg_net_id, rand8(), rand8(), 8'd2, 8'h00);
        pkt_bytes.push_back(cfg_header);
        add_noise(2, 1'b0);
        send_packet();
        build_frame(cfg_command, cfg_net_id, rand8(), rand8(), 8'd2, 8'h00);
        send_packet();
        settle();
    endtask

    task automatic frames_under_config();
        build_frame(cfg_command, cfg_net_id, rand8(), rand8(), 8'd3, 8'h00);
        send_packet();
        add_noise(4, 1'b1);
        send_packet();
        build_frame(cfg_command ^ 8'h80, cfg_net_id, rand8(), rand8(), 8'd2, 8'h00);
        send_packet();
        build_frame(cfg_command, cfg_net_id ^ 16'h0100, rand8(), rand8(), 8'd2, 8'h00);
        send_packet();
        settle();
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_HEADER, 16'h0000);
        write_reg(CFG_COMMAND, 16'h00FF);
        write_reg(CFG_NET_ID, 16'h0000);
        frames_under_config();
        write_reg(CFG_HEADER, 16'h00FF);
        write_reg(CFG_COMMAND, 16'h0000);
        write_reg(CFG_NET_ID, 16'hFFFF);
        frames_under_config();
        write_reg(CFG_HEADER, {8'h00, HEADER_RST});
        write_reg(CFG_COMMAND, {8'h00, COMMAND_RST});
        write_reg(CFG_NET_ID, NET_ID_RST);
    endtask

    task automatic test_random_traffic();
        int          start;
        int          packets;
        int          pick;
        logic [7:0]  cmd;
        logic [7:0]  len;
        logic [7:0]  flip;
        logic [15:0] net;
        logic [15:0] value;
        start   = bytes_sent;
        packets = 0;
        while (bytes_sent - start < RANDOM_BYTES) begin
            // no idling on either side through the middle of the run
            idling_on = !((bytes_sent - start) >= 600 && (bytes_sent - start) < 1000);
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                add_noise($urandom_range(1, 6), 1'b1);
            end else if (pick < 16) begin
                add_noise($urandom_range(1, 10), 1'b0);
            end else begin
                if ($urandom_range(0, 3) == 0)
                    add_noise($urandom_range(1, 3), 1'b1);
                cmd = ($urandom_range(0, 9) == 0) ? rand8() : cfg_command;
                net = cfg_net_id;
                if ($urandom_range(0, 9) == 0)
                    net = net ^ (16'd1 << $urandom_range(0, 15));
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    len = 8'd0;
                else if (pick < 6)
                    len = 8'd255;
                else if (pick < 16)
                    len = 8'($urandom_range(9, 40));
                else
                    len = 8'($urandom_range(1, 8));
                flip = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
                build_frame(cmd, net, rand8(), rand8(), len, flip);
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    cut_packet($urandom_range(1, pkt_bytes.size() - 1));
                else if (pick < 35)
                    add_noise($urandom_range(1, 3), 1'b0);
            end
            send_packet();
            packets++;
            if (packets % 30 == 0) begin
                settle();
                pick = $urandom_range(0, 3);
                if (pick == 0)
                    value = 16'h0000;
                else if (pick == 1)
                    value = 16'hFFFF;
                else
                    value = 16'($urandom);
                case ($urandom_range(0, 2))
                    0: write_reg(CFG_HEADER, {8'h00, value[7:0]});
                    1: write_reg(CFG_COMMAND, {8'h00, value[7:0]});
                    default: write_reg(CFG_NET_ID, value);
                endcase
            end
        end
        idling_on = 1'b1;
        settle();
    endtask

    initial begin
        cfg_header  = HEADER_RST;
        cfg_command = COMMAND_RST;
        cfg_net_id  = NET_ID_RST;
        ph          = PH_HUNT;
        sum_acc     = '0;
        bytes_left  = '0;
        net_hi      = '0;
        held_addr   = '0;
        held_ack    = '0;
        cmd_bad     = 1'b0;
        net_bad     = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_good_frames();
        test_status_codes();
        test_register_extremes();
        test_random_traffic();

        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_replies.size() == 0)
            $display("sensor_reply_frame_checker_top_tb: PASS");
        else
            $display("sensor_reply_frame_checker_top_tb: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
sv/sfc_pkg.sv
sv/sfc_in_stage.sv
sv/sfc_parser.sv
sv/sfc_out_stage.sv
sv/sensor_reply_frame_checker_top.sv
tb/sensor_reply_frame_checker_top_tb.sv
